[rtl/gdp_pkg.sv]
// Shared widths and the stage control type for the GF(2^51) dot product.
// No dependencies; imported by every module of the block.
package gdp_pkg;

  localparam int unsigned ElemW  = 51;              // field element width
  localparam int unsigned ProdW  = 2 * ElemW - 1;   // carry-less product width
  localparam int unsigned UpW    = ProdW - ElemW;   // coefficients x^51 .. x^100
  localparam int unsigned FoldA  = 45;
  localparam int unsigned FoldB  = 48;
  localparam int unsigned FoldC  = 50;
  localparam int unsigned TapTop = 6;
  localparam int unsigned TapMid = 3;
  localparam int unsigned TapLow = 1;

  typedef logic [ElemW-1:0] elem_t;
  typedef logic [ProdW-1:0] prod_t;
  typedef logic [UpW-1:0]   up_t;

  // Control carried alongside a payload between stages
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

[rtl/gdp_clmul.sv]
// Product stage: 51x51 carry-less multiply into a registered 101-bit product.
// Depends on gdp_pkg.
module gdp_clmul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               take_i,
  input  logic               last_i,
  input  gdp_pkg::elem_t     lhs_i,
  input  gdp_pkg::elem_t     rhs_i,
  output gdp_pkg::stage_ctl_t ctl_o,
  output gdp_pkg::prod_t     prod_o
);
  import gdp_pkg::*;

  stage_ctl_t ctl_q, ctl_d;
  prod_t      prod_q, prod_d;

  // XOR tree over the partial products
  always_comb begin
    prod_d = '0;
    for (int i = 0; i < ElemW; i++) begin
      if (rhs_i[i]) begin
        prod_d = prod_d ^ (ProdW'(lhs_i) << i);
      end
    end
  end

  always_comb begin
    ctl_d = ctl_q;
    if (load_i) begin
      ctl_d.valid = 1'b1;
      ctl_d.last  = last_i;
    end else if (take_i) begin
      ctl_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign prod_o = prod_q;

endmodule

[rtl/gdp_acc_reduce.sv]
// Accumulate stage: XOR products into the unreduced accumulator, fold it
// modulo x^51+x^6+x^3+x+1 on the last pair and hold the result. Uses gdp_pkg.
module gdp_acc_reduce (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gdp_pkg::stage_ctl_t ctl_i,
  input  gdp_pkg::prod_t      prod_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gdp_pkg::elem_t      dot_result_o
);
  import gdp_pkg::*;

  prod_t acc_q, acc_d;
  prod_t acc_sum;
  elem_t result_q, result_d;
  logic  out_valid_q, out_valid_d;
  logic  blocked;
  up_t   up_raw, up_fold;
  elem_t lo_part;

  assign blocked = out_valid_q && out_stall_i;
  // A non-last product never needs the output register
  assign take_o  = ctl_i.valid && (!ctl_i.last || !blocked);
  assign acc_sum = acc_q ^ prod_i;

  always_comb begin
    up_raw  = acc_sum[ProdW-1:ElemW];
    lo_part = acc_sum[ElemW-1:0];
    up_fold = up_raw ^ (up_raw >> FoldA) ^ (up_raw >> FoldB) ^ (up_raw >> FoldC);
    // widen to the element width before shifting so the top coefficient survives
    result_d = lo_part
             ^ (ElemW'(up_fold) << TapTop)
             ^ (ElemW'(up_fold) << TapMid)
             ^ (ElemW'(up_fold) << TapLow)
             ^ ElemW'(up_fold);
  end

  always_comb begin
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (take_o) begin
      if (ctl_i.last) begin
        acc_d       = '0;
        out_valid_d = 1'b1;
      end else begin
        acc_d = acc_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && ctl_i.last) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dot_result_o = result_q;

endmodule

[rtl/gf2_51_dot_product.sv]
// Streaming GF(2^51) dot product: one pair per cycle, result on the last pair.
// A last pair goes from the input register to the product register; its result
// is then registered. Throughput: one pair per cycle unless stalled; the input,
// product and result registers each hold one transaction, so a stalled result
// blocks only behind a last pair. Reset clears the valid flags and accumulator.
module gf2_51_dot_product (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gdp_pkg::elem_t      lhs_element_i,
  input  gdp_pkg::elem_t      rhs_element_i,
  input  logic                last_pair_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gdp_pkg::elem_t      dot_result_o
);
  import gdp_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic       last_q;
  elem_t      lhs_q, rhs_q;
  logic       in_accept;
  logic       advance;
  logic       take;
  stage_ctl_t p_ctl;
  prod_t      prod;

  // Advance the input register when the product stage is empty or draining
  assign advance    = in_valid_q && (!p_ctl.valid || take);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      lhs_q  <= lhs_element_i;
      rhs_q  <= rhs_element_i;
      last_q <= last_pair_i;
    end
  end

  gdp_clmul u_clmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .take_i (take),
    .last_i (last_q),
    .lhs_i  (lhs_q),
    .rhs_i  (rhs_q),
    .ctl_o  (p_ctl),
    .prod_o (prod)
  );

  gdp_acc_reduce u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (p_ctl),
    .prod_i       (prod),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dot_result_o (dot_result_o)
  );

endmodule

[rtl/gdp_checker.sv]
// Port-level checker for gf2_51_dot_product, attached by bind below.
// Depends on gdp_pkg for the element type.
module gdp_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_o,
  input  logic           last_pair_i,
  input  logic           out_valid_o,
  input  logic           out_stall_i,
  input  gdp_pkg::elem_t dot_result_o
);
  import gdp_pkg::*;

  logic [2:0] pending_q, pending_d;
  logic       in_last_acc;
  logic       out_acc;

  assign in_last_acc = in_valid_i && !in_stall_o && last_pair_i;
  assign out_acc     = out_valid_o && !out_stall_i;

  // Count last pairs taken whose result is not yet delivered
  always_comb begin
    pending_d = pending_q;
    if (in_last_acc && !out_acc) begin
      pending_d = pending_q + 3'd1;
    end else if (!in_last_acc && out_acc) begin
      pending_d = pending_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(dot_result_o))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != 3'd0)
    else $error("result without a pending last pair");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3)
    else $error("more pending results than pipeline stages");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output is free");

endmodule

bind gf2_51_dot_product gdp_checker u_gdp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .last_pair_i  (last_pair_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .dot_result_o (dot_result_o)
);

[tb/sv/gf2_51_dot_product_mon.sv]
// Channel monitor for the GF(2^51) dot product: predicts each reduced inner
// product from the accepted pairs and compares it with the accepted results.
// Depends on gdp_pkg for the element and product widths.
module gf2_51_dot_product_mon (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  gdp_pkg::elem_t lhs_element_i,
  input  gdp_pkg::elem_t rhs_element_i,
  input  logic           last_pair_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  gdp_pkg::elem_t dot_result_i,
  output int             err_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gdp_pkg::*;

  elem_t dot_expect_q[$];
  prod_t pair_sum;
  elem_t want;
  int    errors;

  initial begin
    err_count_o = 0;
    pending_o   = 0;
  end

  function automatic prod_t clmul_51(elem_t a, elem_t b);
    prod_t p;
    p = '0;
    for (int i = 0; i < ElemW; i++) begin
      if (b[i]) begin
        p ^= prod_t'(a) << i;
      end
    end
    return p;
  endfunction

  // Two folding passes with x^51 = x^6 + x^3 + x + 1
  function automatic elem_t fold_to_field(prod_t acc);
    logic [63:0] up;
    logic [63:0] low;
    up   = 64'(acc[ProdW-1:ElemW]);
    up   = up ^ (up >> FoldA) ^ (up >> FoldB) ^ (up >> FoldC);
    low  = 64'(acc[ElemW-1:0]);
    low ^= (up << TapTop) ^ (up << TapMid) ^ (up << TapLow) ^ up;
    return low[ElemW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_sum = '0;
      errors   = 0;
      dot_expect_q.delete();
    end else begin
      // a result never leaves at the edge that takes its last pair, so check first
      if (out_valid_i && !out_stall_i) begin
        if (dot_expect_q.size() == 0) begin
          errors++;
          $display("%0t: dot_result expected none, actual %h", $time, dot_result_i);
        end else begin
          want = dot_expect_q.pop_front();
          if (dot_result_i !== want) begin
            errors++;
            $display("%0t: dot_result expected %h, actual %h", $time, want, dot_result_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pair_sum ^= clmul_51(lhs_element_i, rhs_element_i);
        if (last_pair_i) begin
          dot_expect_q.push_back(fold_to_field(pair_sum));
          pair_sum = '0;
        end
      end
    end
    err_count_o <= errors;
    pending_o   <= dot_expect_q.size();
  end

endmodule

[tb/sv/gf2_51_dot_product_tb.sv]
// Top of the GF(2^51) dot product bench: clock, reset, pair stimulus, result
// back-pressure and verdict. Depends on gdp_pkg, the block and its monitor.
module gf2_51_dot_product_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gdp_pkg::*;

  localparam int NumPairs  = 650;
  localparam int CalmTail  = 100;
  localparam int LongHold  = 60;
  localparam int StuckMax  = 1000;
  localparam int DrainWait = 8;

  logic  clk_i         = 1'b0;
  logic  rst_ni        = 1'b0;
  logic  in_valid_i    = 1'b0;
  logic  in_stall_o;
  elem_t lhs_element_i = '0;
  elem_t rhs_element_i = '0;
  logic  last_pair_i   = 1'b0;
  logic  out_valid_o;
  logic  out_stall_i   = 1'b0;
  elem_t dot_result_o;

  int    err_count;
  int    pending;
  int    pairs_sent = 0;
  int    stuck_cycles = 0;
  bit    gaps_on = 1'b1;
  bit    hold_now = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  gf2_51_dot_product dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .lhs_element_i(lhs_element_i),
    .rhs_element_i(rhs_element_i),
    .last_pair_i  (last_pair_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dot_result_o (dot_result_o)
  );

  gf2_51_dot_product_mon u_mon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .lhs_element_i(lhs_element_i),
    .rhs_element_i(rhs_element_i),
    .last_pair_i  (last_pair_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dot_result_i (dot_result_o),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  function automatic elem_t pick_elem();
    elem_t e;
    e = '0;
    case ($urandom_range(0, 9))
      0: e = '0;
      1: e = '1;
      2: e[$urandom_range(0, ElemW - 1)] = 1'b1;
      3: begin
        e = elem_t'({$urandom(), $urandom()});
        e[ElemW-1] = 1'b1;
      end
      default: e = elem_t'({$urandom(), $urandom()});
    endcase
    return e;
  endfunction

  // Offer one pair and hold it until the block takes it
  task automatic send_pair(elem_t a, elem_t b, logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    lhs_element_i <= a;
    rhs_element_i <= b;
    last_pair_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    pairs_sent++;
  endtask

  task automatic send_vector(int len);
    for (int k = 0; k < len; k++) begin
      send_pair(pick_elem(), pick_elem(), k == len - 1);
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off to back up the pipe
  initial begin : result_side
    bit hold_taken;
    hold_taken = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_now && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= StuckMax) begin
        $display("[gf2_51_dot_product] ERROR");
        $finish;
      end
    end
  end

  initial begin : pair_side
    elem_t top_bit;
    elem_t a;
    elem_t b;
    top_bit = '0;
    top_bit[ElemW-1] = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single pairs: zeros, ones, identity, highest degree product
    send_pair('0, '0, 1'b1);
    send_pair('1, '1, 1'b1);
    send_pair(elem_t'(1), elem_t'(2), 1'b1);
    send_pair(top_bit, top_bit, 1'b1);
    send_pair('1, elem_t'(1), 1'b1);
    send_pair(top_bit, '1, 1'b1);
    send_pair('0, '1, 1'b1);
    // accumulate several pairs before the last one
    send_pair('1, top_bit, 1'b0);
    send_pair(elem_t'({$urandom(), $urandom()}), '1, 1'b0);
    send_pair(top_bit, elem_t'(3), 1'b0);
    send_pair('1, '1, 1'b1);
    // same pair twice cancels to zero
    a = elem_t'({$urandom(), $urandom()});
    b = elem_t'({$urandom(), $urandom()});
    send_pair(a, b, 1'b0);
    send_pair(a, b, 1'b1);
    // the accumulator must start clean after a result
    send_pair(elem_t'(1), elem_t'(1), 1'b1);
    send_pair('0, top_bit, 1'b0);
    send_pair(top_bit, '0, 1'b1);
    send_pair('1, '1, 1'b0);
    send_pair('1, '1, 1'b0);
    send_pair('1, '1, 1'b1);

    // hold the result side while short vectors keep coming
    hold_now = 1'b1;
    while (pairs_sent < NumPairs) begin
      if (pairs_sent >= NumPairs - CalmTail) begin
        gaps_on = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_vector($urandom_range(5, 24));
      end else begin
        send_vector($urandom_range(1, 4));
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("[gf2_51_dot_product] OK");
    end else begin
      $display("[gf2_51_dot_product] ERROR");
    end
    $finish;
  end

endmodule
